/* hw/rtl/ihex_pkg.sv */
// Shared types and constants for the Intel HEX record loader.
package ihex_pkg;

    // Result kinds
    localparam logic [1:0] KIND_WRITE = 2'd0;
    localparam logic [1:0] KIND_EOF   = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    // Request commands
    localparam logic CMD_CHAR    = 1'b0;
    localparam logic CMD_RESTART = 1'b1;

    // Character classes; 0..15 are hex digit values
    localparam logic [4:0] CLS_SPACE = 5'd16;
    localparam logic [4:0] CLS_PLUS  = 5'd17;
    localparam logic [4:0] CLS_MINUS = 5'd18;
    localparam logic [4:0] CLS_OTHER = 5'd19;

    localparam logic [7:0] CH_COLON = 8'h3a;
    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_PLUS  = 8'h2b;
    localparam logic [7:0] CH_MINUS = 8'h2d;

    localparam logic [7:0] REC_DATA = 8'h00;
    localparam logic [7:0] REC_EOF  = 8'h01;

    typedef enum logic [2:0] {
        PH_START,
        PH_COUNT,
        PH_ADDR,
        PH_TYPE,
        PH_DATA,
        PH_CSUM,
        PH_AFTER_CS,
        PH_AFTER_CR
    } phase_t;

    // One classified request, as held in the queue
    typedef struct packed {
        logic       cmd;
        logic       is_hex;
        logic [3:0] hex;
        logic [4:0] cls;
        logic       is_colon;
        logic       is_cr;
        logic       is_lf;
    } char_info_t;

endpackage

/* hw/rtl/intel_hex_record_loader.sv */
// Top level of the Intel HEX record loader: front, queue and back.
//
//  channel | signals                                  | direction
//  --------+------------------------------------------+----------
//  in      | in_valid, in_ready, cmd, char_in         | request in
//  out     | out_valid, out_ready, kind, write_addr,  | result out
//          | write_data                               |
//
// One character per cycle sustained while the output is not stalled; a taken request is
// written into the queue, and the queue head is decoded straight into the result register.
// The parser state machine in the back end updates once per character.
// rst_n clears the queue and the parser; the block then ignores characters
// until a restart request. An output stall fills the queue, then drops in_ready.
module intel_hex_record_loader
    import ihex_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        cmd,
    input  logic [7:0]  char_in,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  kind,
    output logic [15:0] write_addr,
    output logic [7:0]  write_data
);

    char_info_t push_info;
    char_info_t head_info;
    logic       push;
    logic       pop;
    logic       q_full;
    logic       q_empty;

    ihex_front u_front (
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .cmd       (cmd),
        .char_in   (char_in),
        .q_full    (q_full),
        .push      (push),
        .push_info (push_info)
    );

    ihex_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_info (push_info),
        .pop       (pop),
        .head_info (head_info),
        .q_full    (q_full),
        .q_empty   (q_empty)
    );

    ihex_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_info  (head_info),
        .q_empty    (q_empty),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .kind       (kind),
        .write_addr (write_addr),
        .write_data (write_data)
    );

endmodule

/* hw/rtl/ihex_front.sv */
// Front end: accepts requests and classifies each character.
module ihex_front
    import ihex_pkg::*;
(
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       cmd,
    input  logic [7:0] char_in,
    input  logic       q_full,
    output logic       push,
    output char_info_t push_info
);

    logic       is_hex;
    logic [3:0] hex;
    logic       is_space;

    always_comb
    begin
        is_hex = 1'b1;
        hex    = 4'h0;
        if (char_in >= 8'h30 && char_in <= 8'h39)
        begin
            hex = 4'(char_in - 8'h30);
        end
        else if (char_in >= 8'h61 && char_in <= 8'h66)
        begin
            hex = 4'(char_in - 8'h57);
        end
        else if (char_in >= 8'h41 && char_in <= 8'h46)
        begin
            hex = 4'(char_in - 8'h37);
        end
        else
        begin
            is_hex = 1'b0;
        end
    end

    // space, TAB, LF, VT, FF, CR
    assign is_space = (char_in == CH_SPACE) || (char_in >= CH_TAB && char_in <= CH_CR);

    always_comb
    begin
        push_info.cmd      = cmd;
        push_info.is_hex   = is_hex;
        push_info.hex      = hex;
        push_info.is_colon = (char_in == CH_COLON);
        push_info.is_cr    = (char_in == CH_CR);
        push_info.is_lf    = (char_in == CH_LF);
        if (is_hex)
            push_info.cls = {1'b0, hex};
        else if (is_space)
            push_info.cls = CLS_SPACE;
        else if (char_in == CH_PLUS)
            push_info.cls = CLS_PLUS;
        else if (char_in == CH_MINUS)
            push_info.cls = CLS_MINUS;
        else
            push_info.cls = CLS_OTHER;
    end

    assign in_ready = !q_full;
    assign push     = in_valid && in_ready;

endmodule

/* hw/rtl/ihex_queue.sv */
// Small FIFO of classified requests between front and back.
module ihex_queue
    import ihex_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  char_info_t push_info,
    input  logic       pop,
    output char_info_t head_info,
    output logic       q_full,
    output logic       q_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST  = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULLC = CW'(DEPTH);

    char_info_t    mem_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;

    assign q_full    = (count_reg == FULLC);
    assign q_empty   = (count_reg == '0);
    assign head_info = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_info;
    end

endmodule

/* hw/rtl/ihex_back.sv */
// Back end: record parser state machine and result register.
module ihex_back
    import ihex_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  char_info_t  head_info,
    input  logic        q_empty,
    output logic        pop,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  kind,
    output logic [15:0] write_addr,
    output logic [7:0]  write_data
);

    phase_t      phase_reg, phase_next;
    logic [4:0]  first_nibble_reg, first_nibble_next;
    logic [7:0]  byte_count_reg, byte_count_next;
    logic [15:0] load_address_reg, load_address_next;
    logic [1:0]  pair_index_reg, pair_index_next;
    logic        stopped_reg, stopped_next;

    logic        out_valid_reg, out_valid_next;
    logic [1:0]  kind_reg, kind_next;
    logic [15:0] addr_reg, addr_next;
    logic [7:0]  data_reg, data_next;

    logic        emit;
    logic [7:0]  pair_byte;
    logic [7:0]  count_dec;

    // Two-character strtol in base 16
    function automatic logic [7:0] decode_pair(input logic [4:0] cls, input char_info_t ci);
        logic [7:0] v;
        v = 8'h00;
        if (!cls[4])
            v = ci.is_hex ? {cls[3:0], ci.hex} : {4'h0, cls[3:0]};
        else if (!ci.is_hex)
            v = 8'h00;
        else if (cls == CLS_SPACE || cls == CLS_PLUS)
            v = {4'h0, ci.hex};
        else if (cls == CLS_MINUS)
            v = 8'h00 - {4'h0, ci.hex};
        return v;
    endfunction

    assign pop       = !q_empty && (!out_valid_reg || out_ready);
    assign pair_byte = decode_pair(first_nibble_reg, head_info);
    assign count_dec = byte_count_reg - 8'd1;

    always_comb
    begin
        phase_next        = phase_reg;
        first_nibble_next = first_nibble_reg;
        byte_count_next   = byte_count_reg;
        load_address_next = load_address_reg;
        pair_index_next   = pair_index_reg;
        stopped_next      = stopped_reg;
        emit              = 1'b0;
        kind_next         = kind_reg;
        addr_next         = addr_reg;
        data_next         = data_reg;

        if (pop)
        begin
            if (head_info.cmd == CMD_RESTART)
            begin
                phase_next        = PH_START;
                first_nibble_next = '0;
                byte_count_next   = '0;
                load_address_next = '0;
                pair_index_next   = '0;
                stopped_next      = 1'b0;
            end
            else if (!stopped_reg)
            begin
                unique case (phase_reg)
                    PH_START, PH_AFTER_CS, PH_AFTER_CR:
                    begin
                        if (phase_reg == PH_AFTER_CS && head_info.is_cr)
                            phase_next = PH_AFTER_CR;
                        else if (phase_reg != PH_START && head_info.is_lf)
                            phase_next = PH_START;
                        else
                        begin
                            // record start check
                            pair_index_next = '0;
                            if (head_info.is_colon)
                                phase_next = PH_COUNT;
                            else
                            begin
                                phase_next   = PH_START;
                                stopped_next = 1'b1;
                                emit         = 1'b1;
                                kind_next    = KIND_ERROR;
                                addr_next    = '0;
                                data_next    = '0;
                            end
                        end
                    end
                    PH_COUNT, PH_ADDR, PH_TYPE, PH_DATA, PH_CSUM:
                    begin
                        if (!pair_index_reg[0])
                        begin
                            first_nibble_next  = head_info.cls;
                            pair_index_next[0] = 1'b1;
                        end
                        else
                        begin
                            pair_index_next = '0;
                            unique case (phase_reg)
                                PH_COUNT:
                                begin
                                    byte_count_next = pair_byte;
                                    phase_next      = PH_ADDR;
                                end
                                PH_ADDR:
                                begin
                                    if (!pair_index_reg[1])
                                    begin
                                        load_address_next = {pair_byte, 8'h00};
                                        pair_index_next   = 2'b10;
                                    end
                                    else
                                    begin
                                        load_address_next = {load_address_reg[15:8], pair_byte};
                                        phase_next        = PH_TYPE;
                                    end
                                end
                                PH_TYPE:
                                begin
                                    if (pair_byte == REC_DATA)
                                        phase_next = (byte_count_reg != 8'd0) ? PH_DATA : PH_CSUM;
                                    else
                                    begin
                                        // unknown types fall back to the ':' check
                                        phase_next = PH_START;
                                        if (pair_byte == REC_EOF)
                                        begin
                                            stopped_next = 1'b1;
                                            emit         = 1'b1;
                                            kind_next    = KIND_EOF;
                                            addr_next    = '0;
                                            data_next    = '0;
                                        end
                                    end
                                end
                                PH_DATA:
                                begin
                                    load_address_next = load_address_reg + 16'd1;
                                    byte_count_next   = count_dec;
                                    if (count_dec == 8'd0)
                                        phase_next = PH_CSUM;
                                    emit      = 1'b1;
                                    kind_next = KIND_WRITE;
                                    addr_next = load_address_reg;
                                    data_next = pair_byte;
                                end
                                default:
                                begin
                                    phase_next = PH_AFTER_CS;
                                end
                            endcase
                        end
                    end
                    default:
                    begin
                        phase_next = PH_START;
                    end
                endcase
            end
        end

        if (emit)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_START;
            first_nibble_reg <= '0;
            byte_count_reg   <= '0;
            load_address_reg <= '0;
            pair_index_reg   <= '0;
            stopped_reg      <= 1'b1;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            phase_reg        <= phase_next;
            first_nibble_reg <= first_nibble_next;
            byte_count_reg   <= byte_count_next;
            load_address_reg <= load_address_next;
            pair_index_reg   <= pair_index_next;
            stopped_reg      <= stopped_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg <= kind_next;
        addr_reg <= addr_next;
        data_reg <= data_next;
    end

    assign out_valid  = out_valid_reg;
    assign kind       = kind_reg;
    assign write_addr = addr_reg;
    assign write_data = data_reg;

endmodule

/* hw/rtl/ihex_checker.sv */
// Port-level checks for the Intel HEX record loader, bound to the top level.
module ihex_checker
    import ihex_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [1:0]  kind,
    input logic [15:0] write_addr,
    input logic [7:0]  write_data
);

    // A stalled result holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(kind)
            && $stable(write_addr) && $stable(write_data))
        else $error("result changed while stalled");

    a_kind_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (kind == KIND_WRITE || kind == KIND_EOF || kind == KIND_ERROR))
        else $error("bad result kind");

    // End and error results carry zero address and data.
    a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind != KIND_WRITE |-> write_addr == 16'h0000 && write_data == 8'h00)
        else $error("nonzero fields on end or error result");

    // Nothing comes out in the cycle after reset is released.
    a_reset_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(rst_n) |-> !out_valid)
        else $error("result right after reset");

    // The input only backs up behind a pending result.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |-> out_valid)
        else $error("input stalled with no result pending");

endmodule

bind intel_hex_record_loader ihex_checker u_ihex_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .kind       (kind),
    .write_addr (write_addr),
    .write_data (write_data)
);
